@@ rtl/murmur_hash_64a_assert.svh @@
`ifndef MURMUR_HASH_64A_ASSERT_SVH
`define MURMUR_HASH_64A_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MH_ASSERT_NOW(lbl, ant, con) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (con)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MH_ASSERT_NEXT(lbl, ant, con) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (con)) \
      else $error("assertion failed");

`endif

@@ rtl/mh64_pkg.sv @@
package mh64_pkg;

   localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
   localparam int unsigned MIX_SHIFT = 47;

   typedef struct packed {
      logic        start;
      logic [63:0] operand;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] product;
   } mul_rsp_type;

   function automatic logic [63:0] tail_mask(input logic [2:0] count);
      logic [63:0] mask;
      mask = '0;
      for (int i = 0; i < 8; i++) begin
         if (3'(i) < count) begin
            mask[i*8 +: 8] = 8'hff;
         end
      end
      return mask;
   endfunction

   function automatic logic [63:0] shift_xor(input logic [63:0] value);
      return value ^ (value >> MIX_SHIFT);
   endfunction

endpackage

@@ rtl/mh64_if.sv @@
interface mh64_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_word;
   logic [31:0] total_length;
   logic        first_word;
   logic        last_word;

   modport source (output valid, output data_word, output total_length,
                   output first_word, output last_word, input ready);
   modport sink   (input valid, input data_word, input total_length,
                   input first_word, input last_word, output ready);
endinterface

interface mh64_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

@@ rtl/mh64_mul.sv @@
module mh64_mul
   import mh64_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   logic        busy_ff, busy_in;
   logic [1:0]  step_ff, step_in;
   logic        done_ff, done_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] op_a;
   logic [31:0] op_b;
   logic [63:0] partial;

   always_comb begin
      case (step_ff)
         2'd0: begin
            op_a = x_ff[31:0];
            op_b = MIX_MUL[31:0];
         end
         2'd1: begin
            op_a = x_ff[31:0];
            op_b = MIX_MUL[63:32];
         end
         default: begin
            op_a = x_ff[63:32];
            op_b = MIX_MUL[31:0];
         end
      endcase
   end

   assign partial = {32'd0, op_a} * {32'd0, op_b};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      x_in    = x_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         busy_in = 1'b1;
         step_in = 2'd0;
         x_in    = mul_req.operand;
      end else if (busy_ff) begin
         if (step_ff == 2'd0) begin
            acc_in = partial;
         end else begin
            acc_in = {acc_ff[63:32] + partial[31:0], acc_ff[31:0]};
         end
         if (step_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 2'd0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      acc_ff <= acc_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = acc_ff;

endmodule

@@ rtl/murmur_hash_64a.sv @@
// Sequencing: a 32x32 multiplier makes each 64-bit product; a middle word runs the MIX1, MIX2
// and FOLD products, a first word runs the length product (INIT) first, a tail word runs the
// TAIL product; the hash is valid after the avalanche product (FIN) plus output load (DONE).
// Flow: one request at a time, ready only while idle: a middle word frees the sequencer when
// FOLD ends, a last word once the hash is loaded into the output register.
// Reset: synchronous, active high; clears seed, running hash, tail count and output valid.
module murmur_hash_64a
   import mh64_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mh64_req_if.sink    req_if,
   mh64_rsp_if.source  rsp_if,
   input  logic        csr_wen,
   input  logic [63:0] csr_wdata
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_INIT = 8'b0000_0010,
      ST_MIX1 = 8'b0000_0100,
      ST_MIX2 = 8'b0000_1000,
      ST_FOLD = 8'b0001_0000,
      ST_TAIL = 8'b0010_0000,
      ST_FIN  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [63:0] seed_ff, seed_in;
   logic [63:0] hash_ff, hash_in;
   logic [63:0] word_ff, word_in;
   logic [2:0]  tail_ff, tail_in;
   logic        open_ff, open_in;
   logic        last_ff, last_in;
   logic        empty_ff, empty_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_hash_ff, rsp_hash_in;
   logic [63:0] start_hash;
   logic        req_accept;
   mul_req_type mul_req;
   mul_rsp_type mul_rsp;

   mh64_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign seed_in      = csr_wen ? csr_wdata : seed_ff;
   assign start_hash   = seed_ff ^ mul_rsp.product;

   always_comb begin
      state_in        = state_ff;
      hash_in         = hash_ff;
      word_in         = word_ff;
      tail_in         = tail_ff;
      open_in         = open_ff;
      last_in         = last_ff;
      empty_in        = empty_ff;
      rsp_hash_in     = rsp_hash_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      mul_req.start   = 1'b0;
      mul_req.operand = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               word_in = req_if.data_word;
               last_in = req_if.last_word;
               if (req_if.first_word) begin
                  tail_in         = req_if.total_length[2:0];
                  open_in         = 1'b1;
                  empty_in        = (req_if.total_length == 32'd0);
                  mul_req.start   = 1'b1;
                  mul_req.operand = {32'd0, req_if.total_length};
                  state_in        = ST_INIT;
               end else if (open_ff) begin
                  mul_req.start = 1'b1;
                  if (req_if.last_word && tail_ff != 3'd0) begin
                     mul_req.operand = hash_ff ^ (req_if.data_word & tail_mask(tail_ff));
                     state_in        = ST_TAIL;
                  end else begin
                     mul_req.operand = req_if.data_word;
                     state_in        = ST_MIX1;
                  end
               end
            end
         end
         ST_INIT: begin
            if (mul_rsp.done) begin
               hash_in       = start_hash;
               mul_req.start = 1'b1;
               if (last_ff && empty_ff) begin
                  mul_req.operand = shift_xor(start_hash);
                  state_in        = ST_FIN;
               end else if (last_ff && tail_ff != 3'd0) begin
                  mul_req.operand = start_hash ^ (word_ff & tail_mask(tail_ff));
                  state_in        = ST_TAIL;
               end else begin
                  mul_req.operand = word_ff;
                  state_in        = ST_MIX1;
               end
            end
         end
         ST_MIX1: begin
            if (mul_rsp.done) begin
               mul_req.start   = 1'b1;
               mul_req.operand = shift_xor(mul_rsp.product);
               state_in        = ST_MIX2;
            end
         end
         ST_MIX2: begin
            if (mul_rsp.done) begin
               mul_req.start   = 1'b1;
               mul_req.operand = hash_ff ^ mul_rsp.product;
               state_in        = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (mul_rsp.done) begin
               hash_in = mul_rsp.product;
               if (last_ff) begin
                  mul_req.start   = 1'b1;
                  mul_req.operand = shift_xor(mul_rsp.product);
                  state_in        = ST_FIN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_TAIL: begin
            if (mul_rsp.done) begin
               mul_req.start   = 1'b1;
               mul_req.operand = shift_xor(mul_rsp.product);
               state_in        = ST_FIN;
            end
         end
         ST_FIN: begin
            if (mul_rsp.done) begin
               hash_in  = shift_xor(mul_rsp.product);
               open_in  = 1'b0;
               tail_in  = 3'd0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold the hash until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = hash_ff;
               hash_in      = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= '0;
         hash_ff      <= '0;
         tail_ff      <= 3'd0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         hash_ff      <= hash_in;
         tail_ff      <= tail_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff     <= word_in;
      last_ff     <= last_in;
      empty_ff    <= empty_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.hash_value = rsp_hash_ff;

endmodule

@@ rtl/mh64_checker.sv @@
`include "murmur_hash_64a_assert.svh"

module mh64_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_first_word,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_hash_value
);

   `MH_ASSERT_NEXT(a_rsp_valid_hold, rsp_valid && !rsp_ready, rsp_valid)
   `MH_ASSERT_NEXT(a_rsp_hash_hold, rsp_valid && !rsp_ready, $stable(rsp_hash_value))
   `MH_ASSERT_NEXT(a_first_busy, req_valid && req_ready && req_first_word, !req_ready)
   `MH_ASSERT_NOW(a_rsp_not_early, $rose(rsp_valid), !$past(req_valid && req_ready))

endmodule

bind murmur_hash_64a mh64_checker u_mh64_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .req_first_word (req_if.first_word),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_hash_value (rsp_if.hash_value)
);
